// ===== sv/omsrs_pkg.sv =====
// Shared types and constants for the offset multiset rank-select block.
// No dependencies.
`default_nettype none
package omsrs_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_ADD      = 2'd1,
        CMD_SUBTRACT = 2'd2,
        CMD_QUERY    = 2'd3
    } cmd_t;

    localparam int VAL_W   = 32;
    localparam int AMT_W   = 30;
    localparam int HELD_W  = 11;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 80;

    // Register index of min_level in the configuration space
    localparam logic REG_MIN_LEVEL = 1'b0;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

// ===== sv/offset_multiset_rank_select.sv =====
// Offset multiset rank select: sorted values in a circular RAM window.
// Insert: written directly into an empty window, else each larger value moves up one slot before the new one is placed.
// Add/subtract: one read-modify-write sweep over the held values through the RAM port.
// Query: one RAM read, skipped when the rank is absent. Result is held in an output register.
// Reset (aresetn, synchronous, active low) clears count, base, departures,
// min_level and handshake state; the RAM content is not cleared.
`default_nettype none
module offset_multiset_rank_select
    import omsrs_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // tdata: cmd[1:0], amount[31:2]
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // tdata: query_value[31:0], query_found[32], insert_dropped[33],
    //        departed_total[65:34], held_count[76:66], zero[79:77]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW:0] CAP_X = (CW + 1)'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE, ST_INSERT, ST_INS_FIN, ST_SWEEP, ST_QUERY, ST_DONE
    } state_t;

    state_t                   state_reg;
    cmd_t                     cmd_reg;
    logic [AMT_W-1:0]         amt_reg;
    logic [AW-1:0]            base_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            idx_reg;
    logic [CW-1:0]            gone_reg;
    logic [VAL_W-1:0]         dep_reg;
    logic signed [VAL_W-1:0]  min_reg;
    logic signed [VAL_W-1:0]  qval_reg;
    logic                     found_reg;
    logic                     drop_reg;
    logic                     out_valid_reg;
    logic [M_DATA_W-1:0]      out_data_reg;

    logic                     ram_we;
    logic [CW-1:0]            wr_idx;
    logic [CW-1:0]            rd_idx;
    logic [VAL_W-1:0]         ram_wdata;
    logic [VAL_W-1:0]         ram_rdata;
    logic [AW-1:0]            ram_waddr;
    logic [AW-1:0]            ram_raddr;

    // Map a logical index onto the circular window
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] j);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(j);
        if (sum >= CAP_X) begin
            sum = sum - CAP_X;
        end
        return sum[AW-1:0];
    endfunction

    omsrs_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode incoming beat
    cmd_t                    in_cmd;
    logic [AMT_W-1:0]        in_amt;
    logic signed [VAL_W-1:0] in_val;
    logic                    in_fire;
    logic                    in_below;
    logic                    in_full;
    logic                    in_rank_ok;
    assign in_cmd  = cmd_t'(s_tdata[1:0]);
    assign in_amt  = s_tdata[31:2];
    assign in_val  = $signed({2'b00, in_amt});
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire = s_tvalid && s_tready;
    assign in_below   = in_val < min_reg;
    assign in_full    = (CW + 1)'(count_reg) == CAP_X;
    assign in_rank_ok = in_amt != '0 && {2'b00, in_amt} <= 32'(count_reg);

    // Sweep arithmetic: saturate the shifted value
    logic signed [VAL_W+1:0] sw_sum;
    logic signed [VAL_W-1:0] sw_new;
    logic                    sw_below;
    logic [CW-1:0]           gone_next;
    logic signed [VAL_W-1:0] ins_val;
    logic                    ins_move;

    always_comb begin
        if (cmd_reg == CMD_SUBTRACT) begin
            sw_sum = $signed({{2{ram_rdata[VAL_W-1]}}, ram_rdata}) - $signed({4'b0000, amt_reg});
        end else begin
            sw_sum = $signed({{2{ram_rdata[VAL_W-1]}}, ram_rdata}) + $signed({4'b0000, amt_reg});
        end
        if (sw_sum > $signed({{2{VAL_MAX[VAL_W-1]}}, VAL_MAX})) begin
            sw_new = VAL_MAX;
        end else if (sw_sum < $signed({{2{VAL_MIN[VAL_W-1]}}, VAL_MIN})) begin
            sw_new = VAL_MIN;
        end else begin
            sw_new = sw_sum[VAL_W-1:0];
        end
        sw_below  = (cmd_reg == CMD_SUBTRACT) && (sw_new < min_reg);
        gone_next = gone_reg + CW'(sw_below);
        ins_val   = $signed({2'b00, amt_reg});
        ins_move  = $signed(ram_rdata) > ins_val;
    end

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        wr_idx    = '0;
        rd_idx    = '0;
        ram_wdata = ram_rdata;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && in_cmd == CMD_INSERT && count_reg == '0) begin
                    ram_we    = 1'b1;
                    ram_wdata = in_val;
                end
                if (in_cmd == CMD_QUERY) begin
                    rd_idx = count_reg - CW'(in_amt);
                end else if (in_cmd == CMD_INSERT) begin
                    rd_idx = count_reg - CW'(1);
                end
            end
            ST_INSERT: begin
                ram_we = 1'b1;
                wr_idx = idx_reg;
                rd_idx = idx_reg - CW'(2);
                ram_wdata = ins_move ? ram_rdata : ins_val;
            end
            ST_INS_FIN: begin
                ram_we    = 1'b1;
                ram_wdata = ins_val;
            end
            ST_SWEEP: begin
                ram_we    = 1'b1;
                wr_idx    = idx_reg;
                rd_idx    = idx_reg + CW'(1);
                ram_wdata = sw_new;
            end
            ST_QUERY, ST_DONE: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        ram_waddr = phys(base_reg, wr_idx);
        ram_raddr = phys(base_reg, rd_idx);
    end

    // Command sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            count_reg     <= '0;
            dep_reg       <= '0;
            min_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == REG_MIN_LEVEL) begin
                min_reg <= pwdata;
            end
            // Drop the result beat once taken, unless a new one replaces it
            if (out_valid_reg && m_tready && state_reg != ST_DONE) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        cmd_reg   <= in_cmd;
                        amt_reg   <= in_amt;
                        qval_reg  <= '0;
                        gone_reg  <= '0;
                        found_reg <= (in_cmd == CMD_QUERY) && in_rank_ok;
                        drop_reg  <= (in_cmd == CMD_INSERT) && !in_below && in_full;
                        idx_reg   <= (in_cmd == CMD_INSERT) ? count_reg : '0;
                        unique case (in_cmd)
                            CMD_INSERT: begin
                                if (in_below || in_full) begin
                                    state_reg <= ST_DONE;
                                end else if (count_reg == '0) begin
                                    count_reg <= CW'(1);
                                    state_reg <= ST_DONE;
                                end else begin
                                    state_reg <= ST_INSERT;
                                end
                            end
                            CMD_ADD, CMD_SUBTRACT: begin
                                state_reg <= (count_reg != '0) ? ST_SWEEP : ST_DONE;
                            end
                            CMD_QUERY: begin
                                state_reg <= in_rank_ok ? ST_QUERY : ST_DONE;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_INSERT: begin
                    if (!ins_move) begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg <= idx_reg - CW'(1);
                        if (idx_reg == CW'(1)) begin
                            state_reg <= ST_INS_FIN;
                        end
                    end
                end
                ST_INS_FIN: begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= ST_DONE;
                end
                ST_SWEEP: begin
                    gone_reg <= gone_next;
                    idx_reg  <= idx_reg + CW'(1);
                    if (idx_reg == count_reg - CW'(1)) begin
                        base_reg  <= phys(base_reg, gone_next);
                        count_reg <= count_reg - gone_next;
                        dep_reg   <= dep_reg + VAL_W'(gone_next);
                        state_reg <= ST_DONE;
                    end
                end
                ST_QUERY: begin
                    qval_reg  <= ram_rdata;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {3'b000, HELD_W'(count_reg), dep_reg,
                                          drop_reg, found_reg, qval_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_MIN_LEVEL) ? min_reg : '0;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (CW + 1)'(count_reg) <= CAP_X) else $error("count above capacity");
    a_base_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (CW + 1)'(base_reg) < CAP_X) else $error("base out of range");
    a_sweep_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SWEEP |-> idx_reg < count_reg) else $error("sweep past count");
    a_out_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[32] && m_tdata[33])) else $error("found with dropped");

endmodule
`default_nettype wire

// ===== sv/omsrs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module omsrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
